>>> design/calendar_slot_pump_scheduler_defines.svh
// assertion macros for the calendar slot pump scheduler
`ifndef CALENDAR_SLOT_PUMP_SCHEDULER_DEFINES_SVH
`define CALENDAR_SLOT_PUMP_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked at every rising clk outside reset
`define CSPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csps assertion failed");

// next-cycle implication
`define CSPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csps assertion failed");

`endif

>>> design/csps_pkg.sv
// types, constants and reset values for the calendar slot pump scheduler
package csps_pkg;

  localparam int SLOTS_PER_PUMP = 8;
  localparam int NUM_SLOTS      = 2 * SLOTS_PER_PUMP;
  localparam int ADDR_W         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCAN_W         = (SLOTS_PER_PUMP > 1) ? $clog2(SLOTS_PER_PUMP) : 1;

  localparam logic [11:0] MIN_PER_DAY  = 12'd1440;
  localparam logic [10:0] MAX_DURATION = 11'd1440;
  localparam logic [10:0] MIN_PER_HOUR = 11'd60;
  localparam logic [6:0]  WDAY_ALL     = 7'h7F;
  localparam logic [11:0] MON_ALL      = 12'h0FFF;
  localparam logic [2:0]  LAST_WDAY    = 3'd6;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  typedef enum logic [1:0] {
    ORG_NONE   = 2'd0,
    ORG_SCHED  = 2'd1,
    ORG_MANUAL = 2'd2
  } origin_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        en;
    logic [10:0] start;
    logic [10:0] dur;
    logic [6:0]  spd;
    logic [30:0] dmask;
    logic [11:0] mmask;
    logic [6:0]  wmask;
  } slot_t;

  localparam slot_t SLOT_DEFAULT = '{
    en:    1'b0,
    start: 11'(6 * MIN_PER_HOUR),
    dur:   11'd10,
    spd:   7'd100,
    dmask: 31'd0,
    mmask: MON_ALL,
    wmask: WDAY_ALL
  };

endpackage

>>> design/calendar_slot_pump_scheduler.sv
// Calendar slot pump scheduler, top level. Write and manual words are taken while idle. A
// tick word with time_valid set scans each pump's slot table through one shared window
// evaluator, each slot taking a registered memory read and then an evaluation, stopping at
// the first matching slot, and then presents that pump's result word until it is taken.
// No new word is taken until both result words have gone out.
module calendar_slot_pump_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic        pump,
  input  logic [2:0]  slot_index,
  input  logic        flag,
  input  logic [10:0] start_minute,
  input  logic [10:0] duration_min,
  input  logic [6:0]  speed_pct,
  input  logic [49:0] calendar_masks,
  input  logic [2:0]  now_weekday,
  input  logic [3:0]  now_month,
  input  logic [4:0]  now_day,
  input  logic [10:0] now_minute,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pump,
  output logic        driven,
  output logic        pump_on,
  output logic [6:0]  drive_speed,
  output logic        state_changed,
  output logic        last
);

  csps_pkg::state_t state, state_next;

  csps_pkg::slot_t mem [csps_pkg::NUM_SLOTS];
  csps_pkg::slot_t rd_slot, cur_slot, wr_word;
  logic [csps_pkg::NUM_SLOTS-1:0] slot_valid;
  logic rd_valid;
  logic [csps_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [csps_pkg::SCAN_W-1:0] scan_cnt;
  logic [6:0] wr_full;
  logic wr_en, accept, is_tick, scan_last, hit, finish, out_take;

  logic time_valid;
  logic pump_sel;
  logic tk_flag;
  logic [2:0] tk_wday;
  logic [3:0] tk_mon;
  logic [4:0] tk_day;
  logic [10:0] tk_now;

  csps_pkg::origin_t origin [2];
  logic [1:0] prev_want, on_st;

  logic [11:0] end_min;
  logic day_ok, win_ok;
  logic want;
  csps_pkg::origin_t org_mid;
  logic drive;

  assign accept   = in_valid && !in_stall;
  assign is_tick  = (mode == csps_pkg::MODE_TICK) && time_valid;
  assign wr_full  = 7'(slot_index) + (pump ? 7'(csps_pkg::SLOTS_PER_PUMP) : 7'd0);
  assign wr_addr  = wr_full[csps_pkg::ADDR_W-1:0];
  assign wr_en    = accept && (mode == csps_pkg::MODE_WRITE) &&
                    (7'(slot_index) < 7'(csps_pkg::SLOTS_PER_PUMP));
  assign cur_slot = rd_valid ? rd_slot : csps_pkg::SLOT_DEFAULT;
  assign scan_last = (scan_cnt == csps_pkg::SCAN_W'(csps_pkg::SLOTS_PER_PUMP - 1));

  always_comb begin
    wr_word       = '0;
    wr_word.en    = flag;
    wr_word.start = start_minute;
    wr_word.dur   = (duration_min > csps_pkg::MAX_DURATION) ? csps_pkg::MAX_DURATION
                                                             : duration_min;
    wr_word.spd   = speed_pct;
    wr_word.wmask = calendar_masks[6:0];
    wr_word.mmask = calendar_masks[18:7];
    wr_word.dmask = calendar_masks[49:19];
  end

  // shared window evaluator
  always_comb begin
    end_min = {1'b0, cur_slot.start} + {1'b0, cur_slot.dur};
    day_ok  = (cur_slot.dmask == '0) ||
              ((tk_day != 5'd0) && cur_slot.dmask[5'(tk_day - 5'd1)]);
    if (end_min <= csps_pkg::MIN_PER_DAY) begin
      win_ok = (tk_now >= cur_slot.start) && ({1'b0, tk_now} < end_min);
    end else begin
      win_ok = (tk_now >= cur_slot.start) ||
               ({1'b0, tk_now} < (end_min - csps_pkg::MIN_PER_DAY));
    end
    hit = cur_slot.en &&
          (tk_wday <= csps_pkg::LAST_WDAY) && cur_slot.wmask[tk_wday] &&
          (tk_mon <= csps_pkg::LAST_MONTH) && cur_slot.mmask[tk_mon] &&
          day_ok && win_ok;
  end

  // pump decision once the scan ends
  always_comb begin
    want    = hit;
    org_mid = (want != prev_want[pump_sel]) ? csps_pkg::ORG_NONE : origin[pump_sel];
    drive   = !tk_flag && (org_mid != csps_pkg::ORG_MANUAL);
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    finish     = 1'b0;
    out_take   = 1'b0;
    unique case (state)
      csps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && is_tick) state_next = csps_pkg::ST_READ;
      end
      csps_pkg::ST_READ: begin
        state_next = csps_pkg::ST_EVAL;
      end
      csps_pkg::ST_EVAL: begin
        finish = hit || scan_last;
        state_next = finish ? csps_pkg::ST_OUT : csps_pkg::ST_READ;
      end
      csps_pkg::ST_OUT: begin
        out_valid = 1'b1;
        out_take  = !out_stall;
        if (!out_stall) state_next = pump_sel ? csps_pkg::ST_IDLE : csps_pkg::ST_READ;
      end
      default: state_next = csps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= csps_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    rd_slot <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_addr] <= 1'b1;
    end
    rd_valid <= slot_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_valid <= 1'b0;
    end else if (cfg_we) begin
      time_valid <= cfg_wdata;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (accept && is_tick) begin
      tk_flag  <= flag;
      tk_wday  <= now_weekday;
      tk_mon   <= now_month;
      tk_day   <= now_day;
      tk_now   <= now_minute;
      pump_sel <= 1'b0;
      rd_addr  <= '0;
      scan_cnt <= '0;
    end else if (state == csps_pkg::ST_EVAL && !finish) begin
      rd_addr  <= rd_addr + csps_pkg::ADDR_W'(1);
      scan_cnt <= scan_cnt + csps_pkg::SCAN_W'(1);
    end else if (out_take && !pump_sel) begin
      pump_sel <= 1'b1;
      rd_addr  <= csps_pkg::ADDR_W'(csps_pkg::SLOTS_PER_PUMP);
      scan_cnt <= '0;
    end
  end

  // pump control state
  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= csps_pkg::ORG_NONE;
      origin[1] <= csps_pkg::ORG_NONE;
      prev_want <= '0;
      on_st     <= '0;
    end else if (accept && mode == csps_pkg::MODE_MANUAL) begin
      origin[pump] <= csps_pkg::ORG_MANUAL;
      on_st[pump]  <= flag;
    end else if (state == csps_pkg::ST_EVAL && finish) begin
      prev_want[pump_sel] <= want;
      origin[pump_sel]    <= drive ? csps_pkg::ORG_SCHED : org_mid;
      if (drive) on_st[pump_sel] <= want;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == csps_pkg::ST_EVAL && finish) begin
      out_pump      <= pump_sel;
      driven        <= drive;
      pump_on       <= drive ? want : on_st[pump_sel];
      drive_speed   <= (drive && want) ? cur_slot.spd : 7'd0;
      state_changed <= drive && (on_st[pump_sel] != want);
      last          <= pump_sel;
    end
  end

endmodule

>>> design/csps_checker.sv
// port-level checker for the calendar slot pump scheduler, with its bind
`include "calendar_slot_pump_scheduler_defines.svh"

module csps_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_pump,
  input logic       driven,
  input logic       pump_on,
  input logic [6:0] drive_speed,
  input logic       state_changed,
  input logic       last
);

  `CSPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pump) && $stable(drive_speed) && $stable(last))
  `CSPS_ASSERT_NOW(a_busy_while_out, out_valid, in_stall)
  `CSPS_ASSERT_NOW(a_last_is_pump1, out_valid, out_pump == last)
  `CSPS_ASSERT_NOW(a_undriven_quiet, out_valid && !driven, drive_speed == 7'd0 && !state_changed)
  `CSPS_ASSERT_NOW(a_off_no_speed, out_valid && !pump_on, drive_speed == 7'd0)

endmodule

bind calendar_slot_pump_scheduler csps_checker u_csps_checker (.*);
